@@ rtl/trs_pkg.sv @@
// trs_pkg: shared types and constants of the token ring station.
// Used by every module of the block except trs_ram; depends on nothing.
package trs_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = 6;
	localparam int CNT_W       = 9;
	localparam int POS_W       = $clog2(MAX_PAYLOAD + 8);
	localparam int CQ_DEPTH    = 2;
	localparam int OUT_DEPTH   = 4;

	typedef enum logic [1:0] {
		KIND_RING,
		KIND_LOAD,
		KIND_SUBMIT,
		KIND_TOKEN
	} kind_t;

	typedef enum logic [2:0] {
		PH_FLAG,
		PH_TOKEN,
		PH_DEST,
		PH_SRC,
		PH_LEN,
		PH_DATA,
		PH_DROP
	} phase_t;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_BYTE,
		JOB_TOKEN,
		JOB_FRAME
	} job_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

	typedef struct packed {
		job_t                   job;
		logic [7:0]             flag;
		logic [7:0]             dest;
		logic [7:0]             addr;
		logic [LEN_W-1:0]       len;
		logic [COUNT_WIDTH-1:0] sent;
		logic [COUNT_WIDTH-1:0] recv;
		logic                   pend;
	} cmd_t;

	typedef struct packed {
		logic [7:0]             out_byte;
		logic                   last;
		logic [COUNT_WIDTH-1:0] sent;
		logic [COUNT_WIDTH-1:0] recv;
		logic                   pend;
	} res_t;

endpackage

@@ rtl/trs_ram.sv @@
// trs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module trs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/trs_front.sv @@
// trs_front: accepts input words, runs the ring receive parser and message state,
// writes payload bytes and issues emit commands. Depends on trs_pkg.
module trs_front import trs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [7:0]        cfg_data,
	input  logic              push,
	input  logic [1:0]        kind,
	input  logic [7:0]        value,
	input  logic [4:0]        index,
	input  logic [7:0]        dest,
	input  logic [5:0]        length,
	output logic              full,
	input  logic              busy,
	input  logic              cq_full,
	output logic              cmd_push,
	output cmd_t              cmd,
	output logic              ram_we,
	output logic [PAY_AW-1:0] ram_waddr,
	output logic [7:0]        ram_wdata
);

	phase_t                 phase_q, phase_n;
	logic [CNT_W-1:0]       cnt_q, cnt_n, cnt_dec;
	logic [7:0]             held_q, held_n;
	logic                   pend_q, pend_n;
	logic [7:0]             pdest_q, pdest_n;
	logic [LEN_W-1:0]       plen_q, plen_n;
	logic [COUNT_WIDTH-1:0] sent_q, sent_n;
	logic [COUNT_WIDTH-1:0] recv_q, recv_n;
	logic [7:0]             station_q;
	logic                   accept;
	job_t                   job;
	logic [7:0]             jbyte;

	assign full   = cq_full | ((kind_t'(kind) == KIND_LOAD) & busy);
	assign accept = push & ~full;
	assign cnt_dec = cnt_q - CNT_W'(1);

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		held_n  = held_q;
		pend_n  = pend_q;
		pdest_n = pdest_q;
		plen_n  = plen_q;
		sent_n  = sent_q;
		recv_n  = recv_q;
		job     = JOB_NONE;
		jbyte   = value;
		ram_we  = 1'b0;
		case (kind_t'(kind))
			KIND_RING: begin
				case (phase_q)
					PH_FLAG: begin
						if (value != 8'd0) begin
							held_n  = value;
							cnt_n   = CNT_W'(3);
							phase_n = PH_TOKEN;
						end else begin
							job     = JOB_BYTE;
							phase_n = PH_DEST;
						end
					end
					PH_TOKEN: begin
						cnt_n = cnt_dec;
						jbyte = held_q;
						if (cnt_dec == '0) begin
							if (pend_q) begin
								job     = JOB_FRAME;
								cnt_n   = CNT_W'(plen_q) + CNT_W'(4);
								phase_n = PH_DROP;
								sent_n  = sent_q + COUNT_WIDTH'(1);
								pend_n  = 1'b0;
							end else begin
								job     = JOB_TOKEN;
								phase_n = PH_FLAG;
							end
						end
					end
					PH_DEST: begin
						if (value == station_q) begin
							recv_n = recv_q + COUNT_WIDTH'(1);
						end
						job     = JOB_BYTE;
						phase_n = PH_SRC;
					end
					PH_SRC: begin
						job     = JOB_BYTE;
						phase_n = PH_LEN;
					end
					PH_LEN: begin
						job     = JOB_BYTE;
						cnt_n   = CNT_W'(value);
						phase_n = (value == 8'd0) ? PH_FLAG : PH_DATA;
					end
					PH_DATA: begin
						job   = JOB_BYTE;
						cnt_n = cnt_dec;
						if (cnt_dec == '0) begin
							phase_n = PH_FLAG;
						end
					end
					PH_DROP: begin
						cnt_n = cnt_dec;
						if (cnt_dec == '0) begin
							phase_n = PH_FLAG;
						end
					end
					default: begin
						phase_n = PH_FLAG;
					end
				endcase
			end
			KIND_LOAD: begin
				ram_we = accept & (LEN_W'(index) < LEN_W'(MAX_PAYLOAD));
			end
			KIND_SUBMIT: begin
				if (!pend_q) begin
					pend_n  = 1'b1;
					pdest_n = dest;
					plen_n  = (length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : length;
				end
			end
			KIND_TOKEN: begin
				job   = JOB_TOKEN;
				jbyte = 8'd1;
			end
			default: begin
				job = JOB_NONE;
			end
		endcase
	end

	assign ram_waddr = PAY_AW'(index);
	assign ram_wdata = value;

	assign cmd_push  = accept & (job != JOB_NONE);
	assign cmd.job   = job;
	assign cmd.flag  = jbyte;
	assign cmd.dest  = pdest_q;
	assign cmd.addr  = station_q;
	assign cmd.len   = plen_q;
	assign cmd.sent  = sent_n;
	assign cmd.recv  = recv_n;
	assign cmd.pend  = pend_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FLAG;
			cnt_q     <= '0;
			held_q    <= '0;
			pend_q    <= 1'b0;
			pdest_q   <= '0;
			plen_q    <= '0;
			sent_q    <= '0;
			recv_q    <= '0;
			station_q <= '0;
		end else begin
			if (cfg_write) begin
				station_q <= cfg_data;
			end
			if (accept) begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				held_q  <= held_n;
				pend_q  <= pend_n;
				pdest_q <= pdest_n;
				plen_q  <= plen_n;
				sent_q  <= sent_n;
				recv_q  <= recv_n;
			end
		end
	end

endmodule

@@ rtl/trs_cmd_queue.sv @@
// trs_cmd_queue: short FIFO of emit commands between front and back.
// Depends on trs_pkg.
module trs_cmd_queue import trs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic full,
	input  logic rd,
	output logic valid,
	output cmd_t head
);

	localparam int AW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CW = $clog2(CQ_DEPTH + 1);

	cmd_t          ent_q [CQ_DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(CQ_DEPTH));
	assign valid = (count_q != '0);
	assign head  = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == AW'(CQ_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == AW'(CQ_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			count_q <= count_q + CW'(wr) - CW'(rd);
		end
	end

endmodule

@@ rtl/trs_back.sv @@
// trs_back: expands emit commands into ring bytes, reads payload from the RAM,
// and holds results in an output FIFO. Depends on trs_pkg.
module trs_back import trs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cq_valid,
	input  cmd_t              cq_head,
	output logic              cq_pop,
	output logic              ram_re,
	output logic [PAY_AW-1:0] ram_raddr,
	input  logic [7:0]        ram_rdata,
	output logic              running,
	input  logic              pop,
	output logic              empty,
	output res_t              res
);

	localparam int FAW = $clog2(OUT_DEPTH);
	localparam int FCW = $clog2(OUT_DEPTH + 1);

	bk_state_t        state_q, state_n;
	cmd_t             cmd_q;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] total, hdr_end, tok_pos;
	logic [7:0]       sel_byte;
	logic             sel_pay;
	logic             room, issue, last_iss, load;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             pay_s1;
	logic             last_s1;
	cmd_t             cmd_s1;

	res_t             fifo_q [OUT_DEPTH];
	logic [FAW-1:0]   fwp_q, frp_q;
	logic [FCW-1:0]   fcnt_q;
	logic             fpop;
	res_t             fin;

	assign hdr_end = POS_W'(cmd_q.len) + POS_W'(4);
	assign tok_pos = pos_q - hdr_end;

	always_comb begin
		sel_pay = 1'b0;
		case (cmd_q.job)
			JOB_FRAME: begin
				total = POS_W'(cmd_q.len) + POS_W'(8);
				if (pos_q == POS_W'(0)) begin
					sel_byte = 8'd0;
				end else if (pos_q == POS_W'(1)) begin
					sel_byte = cmd_q.dest;
				end else if (pos_q == POS_W'(2)) begin
					sel_byte = cmd_q.addr;
				end else if (pos_q == POS_W'(3)) begin
					sel_byte = 8'(cmd_q.len);
				end else if (pos_q < hdr_end) begin
					sel_byte = 8'd0;
					sel_pay  = 1'b1;
				end else begin
					sel_byte = (tok_pos == '0) ? cmd_q.flag : 8'd0;
				end
			end
			JOB_TOKEN: begin
				total    = POS_W'(4);
				sel_byte = (pos_q == '0) ? cmd_q.flag : 8'd0;
			end
			default: begin
				total    = POS_W'(1);
				sel_byte = cmd_q.flag;
			end
		endcase
	end

	assign room      = (fcnt_q + FCW'(valid_s1)) < FCW'(OUT_DEPTH);
	assign ram_raddr = PAY_AW'(pos_q - POS_W'(4));
	assign ram_re    = issue & sel_pay;
	assign running   = (state_q == BK_RUN);

	always_comb begin
		state_n  = state_q;
		pos_n    = pos_q;
		issue    = 1'b0;
		last_iss = 1'b0;
		load     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cq_valid) begin
					load    = 1'b1;
					state_n = BK_RUN;
				end
			end
			BK_RUN: begin
				if (room) begin
					issue = 1'b1;
					pos_n = pos_q + POS_W'(1);
					if (pos_q == total - POS_W'(1)) begin
						last_iss = 1'b1;
						load     = cq_valid;
						state_n  = cq_valid ? BK_RUN : BK_IDLE;
					end
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
		if (load) begin
			pos_n = '0;
		end
	end

	assign cq_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_n;
			pos_q    <= pos_n;
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cq_head;
		end
		if (issue) begin
			byte_s1 <= sel_byte;
			pay_s1  <= sel_pay;
			last_s1 <= last_iss;
			cmd_s1  <= cmd_q;
		end
	end

	assign fin.out_byte = pay_s1 ? ram_rdata : byte_s1;
	assign fin.last     = last_s1;
	assign fin.sent     = cmd_s1.sent;
	assign fin.recv     = cmd_s1.recv;
	assign fin.pend     = cmd_s1.pend;

	assign empty = (fcnt_q == '0);
	assign fpop  = pop & ~empty;
	assign res   = fifo_q[frp_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[fwp_q] <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwp_q  <= '0;
			frp_q  <= '0;
			fcnt_q <= '0;
		end else begin
			if (valid_s1) begin
				fwp_q <= (fwp_q == FAW'(OUT_DEPTH - 1)) ? '0 : fwp_q + FAW'(1);
			end
			if (fpop) begin
				frp_q <= (frp_q == FAW'(OUT_DEPTH - 1)) ? '0 : frp_q + FAW'(1);
			end
			fcnt_q <= fcnt_q + FCW'(valid_s1) - FCW'(fpop);
		end
	end

endmodule

@@ rtl/token_ring_station_top.sv @@
// Token ring station: front parser, command queue, payload RAM, byte emitter.
// Commands pass the command queue, emitter's command register and stage 1 to the output FIFO.
// Throughput: ring bytes 1 word per cycle unless full; a frame is length+8 emitted bytes.
// Payload loads wait while any emit command is queued or running (shared payload RAM).
// Reset: arst_n clears parser, counters, pending message and queues; payload RAM is not cleared.
module token_ring_station_top import trs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [7:0]             cfg_data,
	input  logic                   push,
	output logic                   full,
	input  logic [1:0]             kind,
	input  logic [7:0]             value,
	input  logic [4:0]             index,
	input  logic [7:0]             dest,
	input  logic [5:0]             length,
	output logic                   empty,
	input  logic                   pop,
	output logic [7:0]             out_byte,
	output logic                   last,
	output logic [COUNT_WIDTH-1:0] sent_count,
	output logic [COUNT_WIDTH-1:0] received_count,
	output logic                   message_pending
);

	logic              cmd_push, cq_full, cq_valid, cq_pop, running, busy;
	cmd_t              cmd, cq_head;
	logic              ram_we, ram_re;
	logic [PAY_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	res_t              res;

	assign busy = running | cq_valid;

	trs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.push      (push),
		.kind      (kind),
		.value     (value),
		.index     (index),
		.dest      (dest),
		.length    (length),
		.full      (full),
		.busy      (busy),
		.cq_full   (cq_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	trs_cmd_queue u_cq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd),
		.full   (cq_full),
		.rd     (cq_pop),
		.valid  (cq_valid),
		.head   (cq_head)
	);

	trs_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PAYLOAD)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	trs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_valid  (cq_valid),
		.cq_head   (cq_head),
		.cq_pop    (cq_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.running   (running),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign out_byte        = res.out_byte;
	assign last            = res.last;
	assign sent_count      = res.sent;
	assign received_count  = res.recv;
	assign message_pending = res.pend;

endmodule

@@ tb/token_ring_station_top_tb.sv @@
`timescale 1ns / 1ps
// token_ring_station_top_tb: self-checking bench for the token ring station.
// Drives ring, load, submit and token words and checks every output word against a
// behavioral predictor of the station; depends on trs_pkg and token_ring_station_top.
module token_ring_station_top_tb import trs_pkg::*;;

	localparam int SETTLE_CYCLES = 64;
	localparam int QUIET_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SEG_WORDS     = 32;

	typedef struct packed {
		kind_t      k;
		logic [7:0] v;
		logic [4:0] ix;
		logic [7:0] d;
		logic [5:0] ln;
		int         exp_n;
		logic [7:0] exp_first;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_write;
	logic [7:0]             cfg_data;
	logic                   push;
	logic                   full;
	logic [1:0]             kind;
	logic [7:0]             value;
	logic [4:0]             index;
	logic [7:0]             dest;
	logic [5:0]             length;
	logic                   empty;
	logic                   pop;
	logic [7:0]             out_byte;
	logic                   last;
	logic [COUNT_WIDTH-1:0] sent_count;
	logic [COUNT_WIDTH-1:0] received_count;
	logic                   message_pending;

	// station state as the predictor sees it
	logic [7:0]             own_addr  = 8'h00;
	phase_t                 rx_ph     = PH_FLAG;
	logic [8:0]             rx_cnt    = '0;
	logic [7:0]             tok_flag  = 8'h00;
	logic                   msg_pend  = 1'b0;
	logic [7:0]             msg_dest  = 8'h00;
	logic [5:0]             msg_len_q = '0;
	logic [7:0]             pay_mem [MAX_PAYLOAD];
	logic [COUNT_WIDTH-1:0] n_sent    = '0;
	logic [COUNT_WIDTH-1:0] n_recv    = '0;

	res_t ring_words_due [$];
	int   words_in    = 0;
	int   errors      = 0;
	int   hold_asked  = 0;
	int   hold_served = 0;
	int   quiet       = 0;
	bit   calm        = 1'b0;

	// a token word and ring bytes, then the special cases: zero length, ignored and oversized submits
	plan_row_t plan [27] = '{
		'{KIND_TOKEN,  8'h00, 5'd0,  8'h00, 6'd0,  4, 8'h01},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  1, 8'h00},
		'{KIND_RING,   8'h00, 5'd31, 8'hFF, 6'd63, 1, 8'h00},
		'{KIND_RING,   8'hFF, 5'd0,  8'h00, 6'd0,  1, 8'hFF},
		'{KIND_RING,   8'h02, 5'd0,  8'h00, 6'd0,  1, 8'h02},
		'{KIND_RING,   8'hFF, 5'd0,  8'h00, 6'd0,  1, 8'hFF},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  1, 8'h00},
		'{KIND_RING,   8'hFF, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'hAA, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h55, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  4, 8'hFF},
		'{KIND_SUBMIT, 8'h00, 5'd0,  8'hFF, 6'd0,  0, 8'h00},
		'{KIND_SUBMIT, 8'h00, 5'd0,  8'h12, 6'd5,  0, 8'h00},
		'{KIND_RING,   8'h80, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  8, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'hFF, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_SUBMIT, 8'h00, 5'd0,  8'h5A, 6'd63, 0, 8'h00},
		'{KIND_RING,   8'h01, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_TOKEN,  8'h00, 5'd0,  8'h00, 6'd0,  4, 8'h01},
		'{KIND_RING,   8'h33, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0,  0, 8'h00},
		'{KIND_RING,   8'h00, 5'd0,  8'h00, 6'd0, 40, 8'h00}
	};

	token_ring_station_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.value          (value),
		.index          (index),
		.dest           (dest),
		.length         (length),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.last           (last),
		.sent_count     (sent_count),
		.received_count (received_count),
		.message_pending(message_pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic station_step(input kind_t k, input logic [7:0] v, input logic [4:0] ix,
			input logic [7:0] d, input logic [5:0] ln, output int n);
		logic [7:0] bytes [$];
		res_t       w;
		if (!(k == KIND_SUBMIT && msg_pend))
			words_in++;
		case (k)
		KIND_RING: begin
			case (rx_ph)
			PH_FLAG: begin
				if (v != 8'h00) begin
					tok_flag = v;
					rx_cnt = 9'd3;
					rx_ph = PH_TOKEN;
				end else begin
					bytes.push_back(v);
					rx_ph = PH_DEST;
				end
			end
			PH_TOKEN: begin
				rx_cnt = rx_cnt - 9'd1;
				if (rx_cnt == 9'd0) begin
					if (msg_pend) begin
						bytes.push_back(8'h00);
						bytes.push_back(msg_dest);
						bytes.push_back(own_addr);
						bytes.push_back({2'b00, msg_len_q});
						for (int i = 0; i < msg_len_q; i++)
							bytes.push_back(pay_mem[i]);
						rx_cnt = 9'(msg_len_q) + 9'd4;
						rx_ph = PH_DROP;
						n_sent++;
						msg_pend = 1'b0;
					end else begin
						rx_ph = PH_FLAG;
					end
					bytes.push_back(tok_flag);
					repeat (3) bytes.push_back(8'h00);
				end
			end
			PH_DEST: begin
				if (v == own_addr)
					n_recv++;
				bytes.push_back(v);
				rx_ph = PH_SRC;
			end
			PH_SRC: begin
				bytes.push_back(v);
				rx_ph = PH_LEN;
			end
			PH_LEN: begin
				bytes.push_back(v);
				rx_cnt = {1'b0, v};
				rx_ph = (v == 8'h00) ? PH_FLAG : PH_DATA;
			end
			PH_DATA: begin
				bytes.push_back(v);
				rx_cnt = rx_cnt - 9'd1;
				if (rx_cnt == 9'd0)
					rx_ph = PH_FLAG;
			end
			PH_DROP: begin
				rx_cnt = rx_cnt - 9'd1;
				if (rx_cnt == 9'd0)
					rx_ph = PH_FLAG;
			end
			default: rx_ph = PH_FLAG;
			endcase
		end
		KIND_LOAD: pay_mem[ix] = v;
		KIND_SUBMIT: begin
			if (!msg_pend) begin
				msg_pend = 1'b1;
				msg_dest = d;
				msg_len_q = (ln > MAX_PAYLOAD) ? 6'(MAX_PAYLOAD) : ln;
			end
		end
		default: begin
			bytes.push_back(8'h01);
			repeat (3) bytes.push_back(8'h00);
		end
		endcase
		n = bytes.size();
		foreach (bytes[i]) begin
			w.out_byte = bytes[i];
			w.last = (i == n - 1);
			w.sent = n_sent;
			w.recv = n_recv;
			w.pend = msg_pend;
			ring_words_due.push_back(w);
		end
	endtask

	task automatic put_word(input kind_t k, input logic [7:0] v, input logic [4:0] ix,
			input logic [7:0] d, input logic [5:0] ln, output int n);
		while (!calm && $urandom_range(99) < 9) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		value <= v;
		index <= ix;
		dest <= d;
		length <= ln;
		do @(posedge clk); while (full);
		station_step(k, v, ix, d, ln, n);
	endtask

	task automatic send_ring_byte(input logic [7:0] v);
		int n;
		put_word(KIND_RING, v, 5'($urandom), 8'($urandom), 6'($urandom), n);
	endtask

	function automatic logic [5:0] pick_msg_len();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 6'($urandom_range(63, 33));
		if (r == 1)
			return 6'(MAX_PAYLOAD);
		return 6'($urandom_range(8));
	endfunction

	task automatic drain_station();
		push <= 1'b0;
		while (ring_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_address(input logic [7:0] a);
		cfg_write <= 1'b1;
		cfg_data <= a;
		@(posedge clk);
		own_addr = a;
		cfg_write <= 1'b0;
	endtask

	// result side: pops at random, or always while calm, with one long hold-off on request
	initial begin
		res_t w;
		int   hold_left;
		hold_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (ring_words_due.size() == 0) begin
					errors++;
					if (errors <= 50)
						$display("%0t: unexpected word: out_byte %h last %b", $time, out_byte, last);
				end else begin
					w = ring_words_due.pop_front();
					if (out_byte !== w.out_byte || last !== w.last || sent_count !== w.sent ||
							received_count !== w.recv || message_pending !== w.pend) begin
						errors++;
						if (errors <= 50)
							$display("%0t: expected %h %b %0d %0d %b, got %h %b %0d %0d %b",
								$time, w.out_byte, w.last, w.sent, w.recv, w.pend,
								out_byte, last, sent_count, received_count, message_pending);
					end
				end
			end
			if (hold_served != hold_asked) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(99) >= 9);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		plan_row_t  row;
		int         n;
		int         r;
		int         target;
		bit         realign;
		kind_t      k;
		logic [7:0] len8;
		logic [7:0] seg_addr [6];

		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_data <= 8'h00;
		push <= 1'b0;
		kind <= KIND_RING;
		value <= 8'h00;
		index <= 5'd0;
		dest <= 8'h00;
		length <= 6'd0;
		seg_addr = '{8'hFF, 8'($urandom), 8'h01, 8'($urandom), 8'h80, 8'($urandom)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_address(8'h00);

		// fill the payload memory so no frame ever reads an unwritten entry
		for (int i = 0; i < MAX_PAYLOAD; i++)
			put_word(KIND_LOAD, 8'($urandom), 5'(i), 8'($urandom), 6'($urandom), n);

		foreach (plan[i]) begin
			row = plan[i];
			put_word(row.k, row.v, row.ix, row.d, row.ln, n);
			if (row.exp_n >= 0 && (n != row.exp_n || (n > 0 &&
					ring_words_due[ring_words_due.size() - n].out_byte != row.exp_first))) begin
				errors++;
				$display("%0t: row %0d: expected %0d words from %h, predicted %0d", $time, i,
					row.exp_n, row.exp_first, n);
			end
		end

		for (int seg = 0; seg < 6; seg++) begin
			drain_station();
			set_address(seg_addr[seg]);
			if (seg == 1)
				hold_asked++;
			calm = (seg == 3);
			target = words_in + SEG_WORDS;
			while (words_in < target) begin
				realign = ($urandom_range(9) < 7);
				while (rx_ph == PH_DROP || (realign && rx_ph != PH_FLAG))
					send_ring_byte((rx_ph == PH_LEN) ? 8'($urandom_range(4)) : 8'($urandom));
				r = $urandom_range(99);
				if (r < 30) begin
					if ($urandom_range(1) == 1)
						put_word(KIND_SUBMIT, 8'($urandom), 5'($urandom), 8'($urandom),
							pick_msg_len(), n);
					send_ring_byte(8'($urandom_range(255, 1)));
					repeat (3) send_ring_byte(8'($urandom));
				end else if (r < 60) begin
					send_ring_byte(8'h00);
					send_ring_byte(($urandom_range(9) < 4) ? own_addr : 8'($urandom));
					send_ring_byte(8'($urandom));
					len8 = ($urandom_range(19) == 0) ? 8'($urandom_range(40, 9))
						: 8'($urandom_range(6));
					send_ring_byte(len8);
					repeat (len8) send_ring_byte(8'($urandom));
				end else if (r < 70) begin
					put_word(KIND_SUBMIT, 8'($urandom), 5'($urandom), 8'($urandom),
						pick_msg_len(), n);
				end else if (r < 80) begin
					repeat ($urandom_range(3, 1))
						put_word(KIND_LOAD, 8'($urandom), 5'($urandom), 8'($urandom),
							6'($urandom), n);
				end else if (r < 88) begin
					put_word(KIND_TOKEN, 8'($urandom), 5'($urandom), 8'($urandom),
						6'($urandom), n);
				end else begin
					repeat ($urandom_range(3, 1)) begin
						k = kind_t'($urandom_range(3));
						put_word(k, (k == KIND_RING && rx_ph == PH_LEN) ? 8'($urandom_range(12))
							: 8'($urandom), 5'($urandom), 8'($urandom), 6'($urandom), n);
					end
				end
			end
		end

		calm = 1'b0;
		drain_station();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
